// File: hdl/swfe_pkg.sv
// Shared constants and types for the sync-word frame extractor.
`default_nettype none

package swfe_pkg;

    localparam int FRAME_BYTES    = 1030;
    localparam int PAYLOAD_BYTES  = 1024;
    localparam int PAYLOAD_OFFSET = 5;
    localparam int FRONT_BYTES    = 6;
    localparam int ADDR_W         = 11;
    localparam int SUM_W          = ADDR_W + 1;
    localparam int INDEX_W        = 10;

    typedef logic [7:0]        t_byte;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [SUM_W-1:0]  t_sum;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam t_byte SYNC0 = 8'hBA;
    localparam t_byte SYNC1 = 8'hDA;
    localparam t_byte SYNC2 = 8'h55;
    localparam t_byte SYNC3 = 8'hAA;

    localparam t_addr FRAME_LAST    = t_addr'(FRAME_BYTES - 1);
    localparam t_addr PAYLOAD_LAST  = t_addr'(FRAME_BYTES - 2);
    localparam t_addr PAYLOAD_FIRST = t_addr'(PAYLOAD_OFFSET);
    localparam t_addr FRONT_COUNT   = t_addr'(FRONT_BYTES);
    localparam t_sum  FRAME_SUM     = t_sum'(FRAME_BYTES);
    localparam t_sum  PAYLOAD_SUM   = t_sum'(PAYLOAD_BYTES);
    localparam t_sum  OFFSET_SUM    = t_sum'(PAYLOAD_OFFSET);
    localparam t_sum  REFILL_SUM    = t_sum'(FRONT_BYTES);

    typedef struct packed {
        logic  wr_en;
        t_addr wr_addr;
        t_byte wr_data;
        logic  rd_en;
        t_addr rd_addr;
    } t_mem_req;

endpackage

`default_nettype wire

// File: hdl/swfe_track.sv
// Window bookkeeping: fill, head, payload XOR and the first window bytes.
`default_nettype none

module swfe_track (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_kind,
    input  swfe_pkg::t_byte                 i_data_byte,
    input  logic [swfe_pkg::INDEX_W-1:0]    i_read_index,
    input  swfe_pkg::t_byte                 i_mem_rdata,
    output swfe_pkg::t_mem_req              o_mem_req,
    output logic                            o_frame_done
);
    import swfe_pkg::*;

    t_addr r_fill, n_fill;
    t_addr r_head, n_head;
    t_byte r_px, n_px;
    logic  r_ld, n_ld;
    t_byte r_front [FRONT_BYTES];
    t_byte n_front [FRONT_BYTES];
    t_byte fr [FRONT_BYTES];

    t_sum wr_sum, rd_sum, refill_sum, head_sum;
    logic match;

    always_comb begin
        fr = r_front;
        // take the byte fetched by the previous slide
        if (r_ld) begin
            fr[FRONT_BYTES-1] = i_mem_rdata;
        end

        wr_sum     = {1'b0, r_head} + {1'b0, r_fill};
        rd_sum     = {1'b0, r_head} + OFFSET_SUM + t_sum'(i_read_index);
        refill_sum = {1'b0, r_head} + REFILL_SUM;
        head_sum   = {1'b0, r_head} + t_sum'(1);

        match = (fr[0] == SYNC0) && (fr[1] == SYNC1) && (fr[2] == SYNC2)
             && (fr[3] == SYNC3) && (r_px == i_data_byte);

        n_front      = fr;
        n_fill       = r_fill;
        n_head       = r_head;
        n_px         = r_px;
        n_ld         = 1'b0;
        o_mem_req    = '0;
        o_frame_done = 1'b0;

        if (i_accept) begin
            if (i_kind == KIND_READ) begin
                o_mem_req.rd_en   = 1'b1;
                o_mem_req.rd_addr = (rd_sum >= FRAME_SUM) ? t_addr'(rd_sum - FRAME_SUM)
                                                          : t_addr'(rd_sum);
            end else begin
                o_mem_req.wr_en   = 1'b1;
                o_mem_req.wr_data = i_data_byte;
                o_mem_req.wr_addr = (wr_sum >= FRAME_SUM) ? t_addr'(wr_sum - FRAME_SUM)
                                                          : t_addr'(wr_sum);
                if (r_fill < FRONT_COUNT) begin
                    n_front[r_fill[2:0]] = i_data_byte;
                end
                if (r_fill >= PAYLOAD_FIRST && r_fill <= PAYLOAD_LAST) begin
                    n_px = r_px ^ i_data_byte;
                end
                if (r_fill == FRAME_LAST) begin
                    if (match) begin
                        // empty the window, keep the stored bytes
                        n_fill       = '0;
                        n_px         = '0;
                        o_frame_done = 1'b1;
                    end else begin
                        // drop the oldest byte and fetch the new last front byte
                        n_head = (head_sum >= FRAME_SUM) ? t_addr'(head_sum - FRAME_SUM)
                                                         : t_addr'(head_sum);
                        n_px   = r_px ^ fr[PAYLOAD_OFFSET] ^ i_data_byte;
                        for (int i = 0; i < FRONT_BYTES - 1; i++) begin
                            n_front[i] = fr[i+1];
                        end
                        n_ld              = 1'b1;
                        o_mem_req.rd_en   = 1'b1;
                        o_mem_req.rd_addr = (refill_sum >= FRAME_SUM)
                                          ? t_addr'(refill_sum - FRAME_SUM)
                                          : t_addr'(refill_sum);
                    end
                end else begin
                    n_fill = r_fill + t_addr'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_head <= '0;
            r_px   <= '0;
            r_ld   <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_head <= n_head;
            r_px   <= n_px;
            r_ld   <= n_ld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
    end

endmodule

`default_nettype wire

// File: hdl/sync_word_frame_extractor.sv
// Top level of the sync-word frame extractor with XOR checksum.
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one beat per received byte
//   (i_kind = data) or per payload read (i_kind = read, i_read_index).
//   Output channel (o_out_valid / i_out_ready) returns exactly one beat for
//   every input beat, in order: o_frame_done for data beats, o_read_data for
//   read beats (the other field is zero).
//   A frame is reported when the last 1030 bytes start with BA DA 55 AA and
//   the XOR of the 1024 payload bytes (after the sequence byte) equals the
//   final byte; the window is then emptied, otherwise it slides by one byte.
//   Reads return the payload of the last frame until new data bytes overwrite it.
// Timing:
//   A beat passes the stage behind the memory read, then the output register.
//   A new beat can be taken every cycle unless the output stalls: the window
//   state sits in one 1030 x 8 memory with one write and one read port, and
//   the first six window bytes, fill level, head and running payload XOR live
//   in registers; a beat needs one write (plus one read on a slide) or one read.
// Reset clears fill, head and XOR; the memory is not cleared.
// When the receiver stalls, the output register holds and the pipeline
// backs up; o_in_ready drops once that stage and the one behind it are full.
`default_nettype none

module sync_word_frame_extractor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_kind,
    input  swfe_pkg::t_byte                 i_data_byte,
    input  logic [swfe_pkg::INDEX_W-1:0]    i_read_index,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_frame_done,
    output swfe_pkg::t_byte                 o_read_data
);
    import swfe_pkg::*;

    t_byte    r_mem [FRAME_BYTES];
    t_byte    r_mem_rdata;
    t_mem_req mem_req;

    logic accept;
    logic s1_adv;
    logic frame_done;
    logic rd_ok;

    // stage behind the memory read
    logic r_s1_valid;
    logic r_s1_kind;
    logic r_s1_done;
    logic r_s1_rd_ok;

    // output register
    logic  r_out_valid;
    logic  r_out_done;
    t_byte r_out_data;

    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;
    assign rd_ok      = t_sum'(i_read_index) < PAYLOAD_SUM;

    swfe_track u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .i_read_index (i_read_index),
        .i_mem_rdata  (r_mem_rdata),
        .o_mem_req    (mem_req),
        .o_frame_done (frame_done)
    );

    // window store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_req.wr_en) begin
            r_mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en) begin
            r_mem_rdata <= r_mem[mem_req.rd_addr];
        end
    end

    // advance the beat past the memory; hold while the output is blocked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind  <= i_kind;
            r_s1_done  <= frame_done;
            r_s1_rd_ok <= rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_done <= (r_s1_kind == KIND_DATA) && r_s1_done;
            r_out_data <= ((r_s1_kind == KIND_READ) && r_s1_rd_ok) ? r_mem_rdata : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_done = r_out_done;
    assign o_read_data  = r_out_data;

endmodule

`default_nettype wire

// File: bench/tb_sync_word_frame_extractor.sv
// Self-checking bench for the sync-word frame extractor against a shadow deframer.
`timescale 1ns / 100ps

module tb_sync_word_frame_extractor;

    import swfe_pkg::*;

    // Pacing of the two channels; the run steps through these in order.
    typedef enum logic [1:0] {
        PACE_SINK_SLOW,     // sender idles 35 %, receiver 66 %
        PACE_SOURCE_SLOW,   // sender idles 66 %, receiver 35 %
        PACE_FULL_RATE      // neither side idles at random
    } t_pace;

    // Ways in which a generated frame can be spoilt.
    typedef enum logic [1:0] {
        FLAW_NONE,
        FLAW_CHECKSUM,
        FLAW_SYNC,
        FLAW_CUT
    } t_flaw;

    typedef struct packed {
        logic                kind;
        t_byte               data;
        logic [INDEX_W-1:0]  index;
    } t_rx_beat;

    typedef struct packed {
        logic  frame_done;
        t_byte read_data;
    } t_verdict;

    localparam int SINK_HOLD_CYCLES = 400;

    // Clock, reset and block inputs, all known from time zero.
    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic               i_kind       = KIND_DATA;
    t_byte              i_data_byte  = '0;
    logic [INDEX_W-1:0] i_read_index = '0;
    logic               i_out_ready  = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_frame_done;
    t_byte              o_read_data;

    sync_word_frame_extractor dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .i_read_index (i_read_index),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_frame_done (o_frame_done),
        .o_read_data  (o_read_data)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus and scoreboard state.
    t_rx_beat    beats_to_send[$];
    t_verdict    verdicts_due[$];
    t_rx_beat    beat_on_wire;
    int unsigned total_beats    = 0;
    int unsigned beats_accepted = 0;
    int unsigned fail_count     = 0;
    t_pace       pace           = PACE_SINK_SLOW;

    // Shadow copy of the deframer: circular window, fill level and head.
    t_byte       shadow_win[FRAME_BYTES];
    int unsigned shadow_fill = 0;
    int unsigned shadow_head = 0;

    function automatic t_byte window_byte(input int unsigned offset);
        return shadow_win[(shadow_head + offset % FRAME_BYTES) % FRAME_BYTES];
    endfunction

    // Advance the shadow deframer by one beat and return the result beat it owes.
    function automatic t_verdict deframe_step(input t_rx_beat b);
        t_verdict    v;
        t_byte       acc;
        logic        framed;
        int unsigned i;
        v = '0;
        if (b.kind == KIND_READ) begin
            if (b.index < PAYLOAD_BYTES) begin
                v.read_data = window_byte(PAYLOAD_OFFSET + b.index);
            end
            return v;
        end
        shadow_win[(shadow_head + shadow_fill) % FRAME_BYTES] = b.data;
        shadow_fill++;
        if (shadow_fill >= FRAME_BYTES) begin
            framed = 1'b0;
            if (window_byte(0) == SYNC0 && window_byte(1) == SYNC1 &&
                window_byte(2) == SYNC2 && window_byte(3) == SYNC3) begin
                acc = '0;
                for (i = 0; i < PAYLOAD_BYTES; i++) begin
                    acc ^= window_byte(PAYLOAD_OFFSET + i);
                end
                framed = (acc == window_byte(FRAME_BYTES - 1));
            end
            if (framed) begin
                // Empty the window; stored bytes stay where they are.
                shadow_fill  = 0;
                v.frame_done = 1'b1;
            end else begin
                // Drop the oldest byte: slide by one.
                shadow_head = (shadow_head + 1) % FRAME_BYTES;
                shadow_fill = FRAME_BYTES - 1;
            end
        end
        return v;
    endfunction

    task automatic queue_byte(input t_byte value);
        t_rx_beat b;
        b.kind  = KIND_DATA;
        b.data  = value;
        b.index = INDEX_W'($urandom);   // ignored on data beats, so scramble it
        beats_to_send.push_back(b);
    endtask

    task automatic queue_read(input int unsigned idx);
        t_rx_beat b;
        b.kind  = KIND_READ;
        b.data  = t_byte'($urandom);    // ignored on read beats
        b.index = idx[INDEX_W-1:0];
        beats_to_send.push_back(b);
    endtask

    // Noise bytes, salted with sync bytes to provoke near misses.
    task automatic queue_noise(input int unsigned count);
        t_byte       pick;
        int unsigned n;
        for (n = 0; n < count; n++) begin
            case ($urandom_range(0, 7))
                0:       pick = SYNC0;
                1:       pick = SYNC1;
                2:       pick = SYNC2;
                3:       pick = SYNC3;
                default: pick = t_byte'($urandom);
            endcase
            queue_byte(pick);
        end
    endtask

    // Queue one frame: sync word, sequence byte, payload, XOR check byte; a cut frame stops in the payload.
    task automatic queue_frame(input t_flaw flaw);
        t_byte       sync_word[4];
        t_byte       csum;
        t_byte       value;
        int unsigned payload_len;
        int unsigned k;
        sync_word[0] = SYNC0;
        sync_word[1] = SYNC1;
        sync_word[2] = SYNC2;
        sync_word[3] = SYNC3;
        if (flaw == FLAW_SYNC) begin
            k = $urandom_range(0, 3);
            sync_word[k] = sync_word[k] ^ (t_byte'(1) << $urandom_range(0, 7));
        end
        for (k = 0; k < 4; k++) begin
            queue_byte(sync_word[k]);
        end
        queue_byte(t_byte'($urandom));
        payload_len = (flaw == FLAW_CUT) ? $urandom_range(1, PAYLOAD_BYTES - 1) : PAYLOAD_BYTES;
        csum = '0;
        for (k = 0; k < payload_len; k++) begin
            value = t_byte'($urandom);
            csum ^= value;
            queue_byte(value);
        end
        if (flaw != FLAW_CUT) begin
            if (flaw == FLAW_CHECKSUM) begin
                csum ^= t_byte'($urandom_range(1, 255));
            end
            queue_byte(csum);
        end
    endtask

    function automatic bit sender_pauses();
        case (pace)
            PACE_SINK_SLOW:   return $urandom_range(0, 99) < 35;
            PACE_SOURCE_SLOW: return $urandom_range(0, 99) < 66;
            default:          return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_pauses();
        case (pace)
            PACE_SINK_SLOW:   return $urandom_range(0, 99) < 66;
            PACE_SOURCE_SLOW: return $urandom_range(0, 99) < 35;
            default:          return 1'b0;
        endcase
    endfunction

    // Driver: on acceptance, predict the result; then offer the next beat or idle.
    // Valid only drops or moves on once the beat on the wire has been taken.
    always @(posedge i_clk) begin : source
        t_rx_beat nxt;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                verdicts_due.push_back(deframe_step(beat_on_wire));
                beats_accepted <= beats_accepted + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (beats_to_send.size() != 0 && !sender_pauses()) begin
                    nxt          = beats_to_send.pop_front();
                    beat_on_wire = nxt;
                    i_in_valid   <= 1'b1;
                    i_kind       <= nxt.kind;
                    i_data_byte  <= nxt.data;
                    i_read_index <= nxt.index;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest prediction, pace the
    // receiver, and once in the full-rate phase hold it off long enough that the
    // block backs up and drops o_in_ready.
    int unsigned sink_hold_left = 0;
    bit          sink_hold_used = 1'b0;

    always @(posedge i_clk) begin : sink
        t_verdict want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdicts_due.size() == 0) begin
                $error("result beat with nothing outstanding: frame_done=%0d read_data=%02h",
                       o_frame_done, o_read_data);
                fail_count++;
            end else begin
                want = verdicts_due.pop_front();
                if (o_frame_done !== want.frame_done) begin
                    $error("frame_done: expected %0d, got %0d", want.frame_done, o_frame_done);
                    fail_count++;
                end
                if (o_read_data !== want.read_data) begin
                    $error("read_data: expected %02h, got %02h", want.read_data, o_read_data);
                    fail_count++;
                end
            end
        end
        if (sink_hold_left != 0) begin
            sink_hold_left <= sink_hold_left - 1;
            i_out_ready    <= 1'b0;
        end else if (!sink_hold_used && pace == PACE_FULL_RATE &&
                     beats_accepted >= total_beats * 5 / 6) begin
            sink_hold_left <= SINK_HOLD_CYCLES;
            sink_hold_used <= 1'b1;
            i_out_ready    <= 1'b0;
        end else begin
            i_out_ready <= !receiver_pauses();
        end
    end

    // Build the whole beat list up front, release reset, step the pacing and
    // wait for every prediction to be met.
    initial begin : run
        t_flaw       flaw;
        int unsigned seg;
        int unsigned n;

        // Directed opening: byte extremes and the sync word, then reads that
        // only touch store entries already written (payload offset 0 and 2).
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(SYNC0);
        queue_byte(SYNC1);
        queue_byte(SYNC2);
        queue_byte(SYNC3);
        queue_byte(8'h5A);
        queue_byte(8'hA5);
        queue_read(0);
        queue_read(2);

        // First clean frame behind that partial header; the window has to slide
        // into alignment. Every store entry is written from here on.
        queue_frame(FLAW_NONE);
        queue_read(0);
        queue_read((1 << INDEX_W) - 1);
        queue_read(10'h155);
        queue_read(10'h2AA);
        // Reads after further data bytes still see the old payload; the new bytes land on the frame start.
        queue_byte(8'h3C);
        queue_byte(8'hC3);
        queue_read(0);
        queue_read(1);
        queue_read((1 << INDEX_W) - 1);

        // Random part: mostly clean frames with random content, the rest broken
        // frames and noise, with reads sprinkled in between.
        for (seg = 0; seg < 16; seg++) begin
            if ($urandom_range(0, 2) == 0) begin
                queue_noise($urandom_range(1, 12));
            end
            case ($urandom_range(0, 9))
                6:       flaw = FLAW_CHECKSUM;
                7:       flaw = FLAW_SYNC;
                8:       flaw = FLAW_CUT;
                default: flaw = FLAW_NONE;
            endcase
            queue_frame(flaw);
            for (n = $urandom_range(0, 6); n != 0; n--) begin
                queue_read($urandom_range(0, (1 << INDEX_W) - 1));
            end
            if ($urandom_range(0, 3) == 0) begin
                queue_noise($urandom_range(1, 4));
                queue_read($urandom_range(0, 3));
            end
        end
        total_beats = beats_to_send.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_accepted < total_beats || verdicts_due.size() != 0) begin
            @(posedge i_clk);
            if (beats_accepted >= 2 * total_beats / 3) begin
                pace <= PACE_FULL_RATE;
            end else if (beats_accepted >= total_beats / 3) begin
                pace <= PACE_SOURCE_SLOW;
            end
        end
        // Let the pipeline drain; anything arriving now is unexpected.
        repeat (8) @(posedge i_clk);
        if (verdicts_due.size() != 0) begin
            $error("%0d result beats never arrived", verdicts_due.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("PASS sync_word_frame_extractor");
        end else begin
            $display("FAIL sync_word_frame_extractor");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #6_000_000;
        $display("FAIL sync_word_frame_extractor");
        $finish;
    end

endmodule

// File: sim.f
hdl/swfe_pkg.sv
hdl/swfe_track.sv
hdl/sync_word_frame_extractor.sv
bench/tb_sync_word_frame_extractor.sv
